// ===== rtl/core/erm_pkg.sv =====
// shared constants, cordic arctangent table and helpers for the rotation matrix unit
// no dependencies
`timescale 1ns / 1ps

package erm_pkg;

  localparam int AngW       = 16;
  localparam int OutW       = 16;
  localparam int StepsTurn  = 23040;
  localparam int StepsQuart = 5760;
  localparam int AccW       = 34;   // q30 cordic datapath with guard bits
  localparam int ZW         = 32;
  localparam int AtanEntries = 31;
  localparam logic [31:0] PiQ30 = 32'd3373259426;
  localparam logic signed [AccW-1:0] GainQ30 = 34'sd652032874;
  localparam logic signed [AccW-1:0] OneQ30  = 34'sd1073741824;

  // atan(2^-i) in q30
  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0: v = 32'sd843314856;   1: v = 32'sd497837829;
      2: v = 32'sd263043836;   3: v = 32'sd133525158;
      4: v = 32'sd67021686;    5: v = 32'sd33543515;
      6: v = 32'sd16775850;    7: v = 32'sd8388437;
      8: v = 32'sd4194282;     9: v = 32'sd2097149;
      10: v = 32'sd1048575;    11: v = 32'sd524287;
      12: v = 32'sd262143;     13: v = 32'sd131071;
      14: v = 32'sd65535;      15: v = 32'sd32767;
      16: v = 32'sd16383;      17: v = 32'sd8191;
      18: v = 32'sd4095;       19: v = 32'sd2047;
      20: v = 32'sd1023;       21: v = 32'sd511;
      22: v = 32'sd255;        23: v = 32'sd127;
      24: v = 32'sd63;         25: v = 32'sd31;
      26: v = 32'sd15;         27: v = 32'sd7;
      28: v = 32'sd3;          29: v = 32'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/euler_rotation_matrix_unit.sv =====
// euler angle to 3x3 rotation matrix, fully pipelined cordic and product tree
// depends on erm_pkg
`timescale 1ns / 1ps
// throughput: one transaction per cycle while the output is not stalled;
// every stage advances together on a global enable
// stall: pipeline freezes only when the output register is full and not taken
// reset: synchronous active low rst_n clears all valid bits; payload is not reset
module euler_rotation_matrix_unit
  import erm_pkg::*;
#(
  parameter int CORDIC_STAGES  = 16,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [AngW-1:0] in_angle_x,
  input  logic signed [AngW-1:0] in_angle_y,
  input  logic signed [AngW-1:0] in_angle_z,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [OutW-1:0] out_r00,
  output logic signed [OutW-1:0] out_r01,
  output logic signed [OutW-1:0] out_r02,
  output logic signed [OutW-1:0] out_r10,
  output logic signed [OutW-1:0] out_r11,
  output logic signed [OutW-1:0] out_r12,
  output logic signed [OutW-1:0] out_r20,
  output logic signed [OutW-1:0] out_r21,
  output logic signed [OutW-1:0] out_r22
);

  localparam int CW   = COEF_FRAC_BITS + 2;        // coefficient width, holds +-1
  localparam int PW   = 2 * CW;                   // product width
  localparam int SW   = PW + 1;                   // sum of two products
  localparam int RSH  = 30 - COEF_FRAC_BITS;       // q30 to coefficient shift
  localparam int ESH  = 2 * COEF_FRAC_BITS - 14;   // product to q1.14 shift
  localparam int NPIPE = CORDIC_STAGES + 11;
  localparam logic signed [CW-1:0] CoefOne = CW'(1) <<< COEF_FRAC_BITS;

  // global advance: the whole pipe stalls only when the output holds a result that is not taken
  logic adv;
  logic [NPIPE-1:0] vld_r;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NPIPE-2:0], in_valid};
    end
  end
  assign out_valid = vld_r[NPIPE-1];

  // ---------------- stage 0: modulo reduction (one compare and add or subtract per step)
  logic signed [AngW:0] ang_in [3];
  logic [14:0] red_nxt [3];
  logic [14:0] red_r   [3];
  assign ang_in[0] = {in_angle_x[AngW-1], in_angle_x};
  assign ang_in[1] = {in_angle_y[AngW-1], in_angle_y};
  assign ang_in[2] = {in_angle_z[AngW-1], in_angle_z};

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [AngW:0] v;
      v = ang_in[a];
      // range -32768..32767 -> 0..23039 with at most two adjustments
      if (v < 0) v = v + 17'(StepsTurn);
      if (v < 0) v = v + 17'(StepsTurn);
      if (v >= 17'(StepsTurn)) v = v - 17'(StepsTurn);
      red_nxt[a] = v[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) red_r <= red_nxt;
  end

  // ---------------- stage 1: negate, split into quadrant and residue
  logic [1:0]  q1_r   [3];
  logic [12:0] rem1_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        logic [14:0] n;
        n = (red_r[a] == '0) ? 15'd0 : 15'(StepsTurn) - red_r[a];
        if (n >= 15'(3 * StepsQuart)) begin
          q1_r[a] <= 2'd3; rem1_r[a] <= 13'(n - 15'(3 * StepsQuart));
        end else if (n >= 15'(2 * StepsQuart)) begin
          q1_r[a] <= 2'd2; rem1_r[a] <= 13'(n - 15'(2 * StepsQuart));
        end else if (n >= 15'(StepsQuart)) begin
          q1_r[a] <= 2'd1; rem1_r[a] <= 13'(n - 15'(StepsQuart));
        end else begin
          q1_r[a] <= 2'd0; rem1_r[a] <= 13'(n);
        end
      end
    end
  end

  // ---------------- stage 2: residue times pi (13x32 multiply)
  logic [1:0]  q2_r   [3];
  logic        zero2_r [3];
  logic [44:0] prod2_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        q2_r[a]    <= q1_r[a];
        zero2_r[a] <= (rem1_r[a] == '0);
        prod2_r[a] <= 45'(rem1_r[a]) * 45'(PiQ30) + 45'(StepsQuart);
      end
    end
  end

  // ---------------- stage 3: divide by 11520 = 2^8 * 45; exact via reciprocal of 45
  // x = prod >> 8 (< 2^37); x/45 computed as (x * ceil(2^43/45)) >> 43 with one correction
  localparam logic [37:0] Recip45 = 38'd195468733827;   // ceil(2^43 / 45)
  logic [1:0]  q3_r   [3];
  logic        zero3_r [3];
  logic [36:0] x3_r   [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        q3_r[a]    <= q2_r[a];
        zero3_r[a] <= zero2_r[a];
        x3_r[a]    <= prod2_r[a][44:8];
      end
    end
  end

  // partial products of the low and high halves of x, summed and corrected in the stage after
  logic [1:0]  q4_r   [3];
  logic        zero4_r [3];
  logic [36:0] x4_r   [3];
  logic [56:0] plo4_r [3];
  logic [56:0] phi4_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        q4_r[a]    <= q3_r[a];
        zero4_r[a] <= zero3_r[a];
        x4_r[a]    <= x3_r[a];
        plo4_r[a]  <= 57'(x3_r[a][18:0]) * 57'(Recip45);
        phi4_r[a]  <= 57'(x3_r[a][36:19]) * 57'(Recip45);
      end
    end
  end

  logic [1:0]  q5_r   [3];
  logic        zero5_r [3];
  logic signed [ZW-1:0] z5_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        logic [79:0] full;
        logic [36:0] qt;
        logic [43:0] chk;
        full = 80'(plo4_r[a]) + (80'(phi4_r[a]) << 19);
        qt   = 37'(full >> 43);
        // correct quotient if estimate overshoots
        chk  = 44'(qt) * 44'd45;
        if (chk > 44'(x4_r[a])) qt = qt - 37'd1;
        q5_r[a]    <= q4_r[a];
        zero5_r[a] <= zero4_r[a];
        z5_r[a]    <= ZW'(qt);
      end
    end
  end

  // ---------------- cordic stages, one register stage per iteration
  logic signed [AccW-1:0] cx_r [CORDIC_STAGES+1][3];
  logic signed [AccW-1:0] cy_r [CORDIC_STAGES+1][3];
  logic signed [ZW-1:0]   cz_r [CORDIC_STAGES+1][3];
  logic [1:0]             cq_r [CORDIC_STAGES+1][3];
  logic                   cb_r [CORDIC_STAGES+1][3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cx_r[0][a] = GainQ30;
      cy_r[0][a] = '0;
      cz_r[0][a] = z5_r[a];
      cq_r[0][a] = q5_r[a];
      cb_r[0][a] = zero5_r[a];
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int a = 0; a < 3; a++) begin
          logic signed [AccW-1:0] dx, dy;
          logic signed [ZW-1:0]   da;
          dx = cy_r[g][a] >>> g;
          dy = cx_r[g][a] >>> g;
          da = atan_q30(g);
          if (!cz_r[g][a][ZW-1]) begin
            cx_r[g+1][a] <= cx_r[g][a] - dx;
            cy_r[g+1][a] <= cy_r[g][a] + dy;
            cz_r[g+1][a] <= cz_r[g][a] - da;
          end else begin
            cx_r[g+1][a] <= cx_r[g][a] + dx;
            cy_r[g+1][a] <= cy_r[g][a] - dy;
            cz_r[g+1][a] <= cz_r[g][a] + da;
          end
          cq_r[g+1][a] <= cq_r[g][a];
          cb_r[g+1][a] <= cb_r[g][a];
        end
      end
    end
  end

  // ---------------- quadrant map, round and saturate to coefficients
  function automatic logic signed [CW-1:0] to_coef(input logic signed [AccW-1:0] v);
    logic signed [AccW:0] t;
    logic signed [AccW:0] lim;
    t = v;
    t = (t + ((AccW+1)'(1) <<< (RSH - 1))) >>> RSH;
    lim = (AccW+1)'(1) <<< COEF_FRAC_BITS;
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    return CW'(t);
  endfunction

  logic signed [CW-1:0] co_r [3];
  logic signed [CW-1:0] si_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        logic signed [AccW-1:0] x, y, c, s;
        x = cb_r[CORDIC_STAGES][a] ? OneQ30 : cx_r[CORDIC_STAGES][a];
        y = cb_r[CORDIC_STAGES][a] ? '0 : cy_r[CORDIC_STAGES][a];
        case (cq_r[CORDIC_STAGES][a])
          2'd0: begin c = x;  s = y;  end
          2'd1: begin c = -y; s = x;  end
          2'd2: begin c = -x; s = -y; end
          default: begin c = y; s = -x; end
        endcase
        co_r[a] <= to_coef(c);
        si_r[a] <= to_coef(s);
      end
    end
  end

  // ---------------- products A*D and B*D, rounded back to coefficients
  logic signed [PW-1:0] ad_p_r, bd_p_r;
  logic signed [CW-1:0] a1_r, b1_r, c1_r, d1_r, e1_r, f1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      ad_p_r <= co_r[0] * si_r[1];
      bd_p_r <= si_r[0] * si_r[1];
      a1_r <= co_r[0]; b1_r <= si_r[0];
      c1_r <= co_r[1]; d1_r <= si_r[1];
      e1_r <= co_r[2]; f1_r <= si_r[2];
    end
  end

  logic signed [CW-1:0] ad2_r, bd2_r, a2_r, b2_r, c2_r, d2_r, e2_r, f2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      ad2_r <= CW'((ad_p_r + (PW'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS);
      bd2_r <= CW'((bd_p_r + (PW'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS);
      a2_r <= a1_r; b2_r <= b1_r; c2_r <= c1_r;
      d2_r <= d1_r; e2_r <= e1_r; f2_r <= f1_r;
    end
  end

  // ---------------- matrix products
  logic signed [PW-1:0] p_ce_r, p_cf_r, p_d_r, p_bde_r, p_af_r, p_ae_r, p_bdf_r;
  logic signed [PW-1:0] p_bc_r, p_bf_r, p_ade_r, p_adf_r, p_be_r, p_ac_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_ce_r  <= c2_r * e2_r;
      p_cf_r  <= c2_r * f2_r;
      p_d_r   <= d2_r * CoefOne;
      p_bde_r <= bd2_r * e2_r;
      p_af_r  <= a2_r * f2_r;
      p_ae_r  <= a2_r * e2_r;
      p_bdf_r <= bd2_r * f2_r;
      p_bc_r  <= b2_r * c2_r;
      p_bf_r  <= b2_r * f2_r;
      p_ade_r <= ad2_r * e2_r;
      p_adf_r <= ad2_r * f2_r;
      p_be_r  <= b2_r * e2_r;
      p_ac_r  <= a2_r * c2_r;
    end
  end

  // ---------------- sums, round to q1.14, saturate
  function automatic logic signed [OutW-1:0] to_entry(input logic signed [SW-1:0] v);
    logic signed [SW:0] t;
    t = {v[SW-1], v};
    if (ESH > 0) t = (t + ((SW+1)'(1) <<< (ESH - 1))) >>> ESH;
    if (t > (SW+1)'(16384)) t = (SW+1)'(16384);
    if (t < -(SW+1)'(16384)) t = -(SW+1)'(16384);
    return OutW'(t);
  endfunction

  function automatic logic signed [SW-1:0] sx(input logic signed [PW-1:0] v);
    return {v[PW-1], v};
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r00 <= to_entry(sx(p_ce_r));
      out_r01 <= to_entry(-sx(p_cf_r));
      out_r02 <= to_entry(sx(p_d_r));
      out_r10 <= to_entry(sx(p_bde_r) + sx(p_af_r));
      out_r11 <= to_entry(sx(p_ae_r) - sx(p_bdf_r));
      out_r12 <= to_entry(-sx(p_bc_r));
      out_r20 <= to_entry(sx(p_bf_r) - sx(p_ade_r));
      out_r21 <= to_entry(sx(p_adf_r) + sx(p_be_r));
      out_r22 <= to_entry(sx(p_ac_r));
    end
  end

endmodule
